[rtl/die_temperature_monitor_defines.svh]
// assertion macros for the die temperature monitor
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef DIE_TEMPERATURE_MONITOR_DEFINES_SVH
`define DIE_TEMPERATURE_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define DTM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DTM_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DTM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/dtm_pkg.sv]
// shared widths, codes, reset values and helpers for the die temperature monitor
// no dependencies
package dtm_pkg;

  // field widths
  localparam int RawW     = 12;
  localparam int TempW    = 11;
  localparam int ThrW     = 10;
  localparam int OffW     = 11;
  localparam int IntW     = 8;
  localparam int KindW    = 2;
  localparam int MvW      = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  // default group size
  localparam int AvgSamplesDefault = 3;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgEventThreshold  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSensorOffset    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSummaryInterval = 2'd2;

  // register reset values
  localparam logic [ThrW-1:0] ThrReset      = 10'd30;
  localparam logic [OffW-1:0] OffsetReset   = 11'd750;
  localparam logic [IntW-1:0] IntervalReset = 8'd10;

  // event codes
  localparam logic [KindW-1:0] KindNone    = 2'd0;
  localparam logic [KindW-1:0] KindWarming = 2'd1;
  localparam logic [KindW-1:0] KindCooling = 2'd2;

  // running extremes start at the ends of the signed range
  localparam logic signed [TempW-1:0] TempMaxValue = 11'sh3FF;
  localparam logic signed [TempW-1:0] TempMinValue = 11'sh400;

  // millivolt conversion: mv = raw * VrefMv >> AdcBits
  localparam int VrefMv  = 1400;
  localparam int VrefW   = 11;
  localparam int AdcBits = 12;

  // tenths conversion: |diff| * 10 / 27 by reciprocal multiply
  localparam int MvPerDegX10 = 27;
  localparam int DegShift    = 20;
  localparam int DegRecip    = 10 * (((1 << DegShift) + MvPerDegX10 - 1) / MvPerDegX10);
  localparam int DegRecipW   = 19;
  localparam int QuotW       = 10;
  localparam int RefTenths   = 250;

  // width of a full group sum
  function automatic int dtm_sum_width(input int n);
    return $clog2(n * ((1 << RawW) - 1) + 1);
  endfunction

  // width of the in-group sample counter
  function automatic int dtm_count_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[rtl/dtm_sample_if.sv]
// sample channel: one raw adc conversion per transfer
// depends on dtm_pkg
interface dtm_sample_if import dtm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

[rtl/dtm_cfg_if.sv]
// configuration write channel: register index and write data
// depends on dtm_pkg
interface dtm_cfg_if import dtm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dtm_result_if.sv]
// result channel: one temperature reading per transfer
// depends on dtm_pkg
interface dtm_result_if import dtm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RawW-1:0]         average_raw;
  logic signed [TempW-1:0] temperature;
  logic signed [TempW-1:0] minimum_seen;
  logic signed [TempW-1:0] maximum_seen;
  logic [KindW-1:0]        event_kind;
  logic                    summary_due;

  modport source (output valid, output average_raw, output temperature,
                  output minimum_seen, output maximum_seen, output event_kind,
                  output summary_due, input ready);
  modport sink   (input valid, input average_raw, input temperature,
                  input minimum_seen, input maximum_seen, input event_kind,
                  input summary_due, output ready);
endinterface

[rtl/dtm_convert.sv]
// four-stage conversion pipeline: group sum -> average -> millivolts -> tenths
// depends on dtm_pkg
module dtm_convert import dtm_pkg::*; #(
  parameter int AVG_SAMPLES = AvgSamplesDefault
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [dtm_sum_width(AVG_SAMPLES)-1:0]  in_sum,
  input  logic [OffW-1:0]                        offset_mv,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [RawW-1:0]                        out_avg,
  output logic signed [TempW-1:0]                out_temp
);

  localparam int SumW     = dtm_sum_width(AVG_SAMPLES);
  localparam int AvgShift = SumW + dtm_count_width(AVG_SAMPLES);
  localparam int AvgRecip = ((1 << AvgShift) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam int RecipW   = AvgShift + 1;
  localparam int AvgProdW = SumW + RecipW;
  localparam int MvProdW  = RawW + VrefW;
  localparam int DiffW    = OffW + 1;
  localparam int QProdW   = OffW + DegRecipW;
  localparam int NumStg   = 4;

  // stage valids and per-stage load enables
  logic [NumStg-1:0] stage_valid;
  logic [NumStg-1:0] stage_ready;

  logic [RawW-1:0]         avg2;
  logic [RawW-1:0]         avg3;
  logic [MvW-1:0]          mv3;
  logic [RawW-1:0]         avg4;
  logic                    neg4;
  logic [QuotW-1:0]        quot4;
  logic [RawW-1:0]         avg5;
  logic signed [TempW-1:0] temp5;

  logic [AvgProdW-1:0]     avg_prod;
  logic [MvProdW-1:0]      mv_prod;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        diff_mag;
  logic [QProdW-1:0]       quot_prod;
  logic [DiffW-1:0]        temp_wide;

  // a stage can load when empty or when its contents move on
  always_comb begin
    stage_ready[NumStg-1] = !stage_valid[NumStg-1] || out_ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_ready = stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // group average: sum / AVG_SAMPLES by exact reciprocal multiply
  assign avg_prod = AvgProdW'(in_sum) * AvgProdW'(AvgRecip);

  // millivolts from the average
  assign mv_prod = MvProdW'(avg2) * MvProdW'(VrefMv);

  // offset-corrected magnitude, divided by 27 after scaling by 10
  assign diff      = $signed({1'b0, mv3}) - $signed({1'b0, offset_mv});
  assign diff_mag  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign quot_prod = QProdW'(diff_mag[OffW-1:0]) * QProdW'(DegRecip);

  // restore sign and add the 25 degree reference
  assign temp_wide = neg4 ? (DiffW'(RefTenths) - DiffW'(quot4))
                          : (DiffW'(RefTenths) + DiffW'(quot4));

  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      avg2 <= avg_prod[AvgShift +: RawW];
    end
    if (stage_ready[1]) begin
      avg3 <= avg2;
      mv3  <= mv_prod[AdcBits +: MvW];
    end
    if (stage_ready[2]) begin
      avg4  <= avg3;
      neg4  <= diff[DiffW-1];
      quot4 <= quot_prod[DegShift +: QuotW];
    end
    if (stage_ready[3]) begin
      avg5  <= avg4;
      temp5 <= $signed(temp_wide[TempW-1:0]);
    end
  end

  assign out_valid = stage_valid[NumStg-1];
  assign out_avg   = avg5;
  assign out_temp  = temp5;

endmodule

[rtl/die_temperature_monitor.sv]
// die temperature monitor: sample averaging, conversion and reading statistics
// depends on dtm_pkg, the channel interfaces, dtm_convert and the defines header
//
// usage
//   sample: one 12-bit adc conversion per transfer; every AVG_SAMPLES transfers
//           close a group, and only a closing transfer leads to a result
//   cfg:    register writes (0 event threshold, 1 sensor offset in mV,
//           2 summary interval); always ready, other indexes are ignored
//   result: average, temperature in tenths of a degree, running min and max,
//           warming/cooling event and summary flag, one per group
// throughput: one sample per cycle unless a stall drops sample.ready; the path
//   is a six-register pipeline (group register, average, millivolts, quotient,
//   temperature, result) with at most one multiplier per stage
// reset: clears the partial group, the pipeline, the statistics and the
//   registers to their defaults (threshold 30, offset 750, interval 10)
// stall: a held result stays on the port; samples are still taken until
//   every pipeline stage is full, then sample.ready drops
`include "die_temperature_monitor_defines.svh"

module die_temperature_monitor import dtm_pkg::*; #(
  parameter int AVG_SAMPLES = AvgSamplesDefault
) (
  input  logic  clk,
  input  logic  rst,
  dtm_sample_if.sink   sample,
  dtm_cfg_if.sink      cfg,
  dtm_result_if.source result
);

  localparam int SumW   = dtm_sum_width(AVG_SAMPLES);
  localparam int CountW = dtm_count_width(AVG_SAMPLES);
  localparam int DeltaW = TempW + 1;

  // configuration registers
  logic [ThrW-1:0] event_threshold;
  logic [OffW-1:0] sensor_offset_mv;
  logic [IntW-1:0] summary_period;

  // group accumulation
  logic [SumW-1:0]   sample_sum;
  logic [CountW-1:0] samples_taken;
  logic [SumW-1:0]   group_sum;
  logic              group_valid;
  logic [SumW-1:0]   sum_next;
  logic              group_close;
  logic              sample_xfer;

  // conversion pipeline
  logic                    conv_ready;
  logic                    conv_valid;
  logic [RawW-1:0]         conv_avg;
  logic signed [TempW-1:0] conv_temp;

  // reading statistics
  logic signed [TempW-1:0] lowest_temp;
  logic signed [TempW-1:0] highest_temp;
  logic signed [TempW-1:0] previous_temp;
  logic                    previous_valid;
  logic [IntW-1:0]         readings_mod_interval;

  logic                     result_ready;
  logic                     reading_take;
  logic signed [TempW-1:0]  lowest_next;
  logic signed [TempW-1:0]  highest_next;
  logic signed [DeltaW-1:0] delta;
  logic signed [DeltaW-1:0] thr_pos;
  logic signed [DeltaW-1:0] thr_neg;
  logic [KindW-1:0]         kind_next;
  logic [IntW-1:0]          interval_eff;
  logic [IntW:0]            count_inc;
  logic                     due_next;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_threshold  <= ThrReset;
      sensor_offset_mv <= OffsetReset;
      summary_period   <= IntervalReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgEventThreshold:  event_threshold  <= cfg.data[ThrW-1:0];
        CfgSensorOffset:    sensor_offset_mv <= cfg.data[OffW-1:0];
        CfgSummaryInterval: summary_period   <= cfg.data[IntW-1:0];
        default: ;
      endcase
    end
  end

  // sample accumulation; a closing transfer loads the group register
  assign sample.ready = !group_valid || conv_ready;
  assign sample_xfer  = sample.valid && sample.ready;
  assign sum_next     = sample_sum + SumW'(sample.raw_sample);
  assign group_close  = (samples_taken == CountW'(AVG_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
      group_valid   <= 1'b0;
    end else begin
      if (conv_ready) begin
        group_valid <= 1'b0;
      end
      if (sample_xfer) begin
        if (group_close) begin
          sample_sum    <= '0;
          samples_taken <= '0;
          group_valid   <= 1'b1;
        end else begin
          sample_sum    <= sum_next;
          samples_taken <= samples_taken + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer && group_close) begin
      group_sum <= sum_next;
    end
  end

  dtm_convert #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (group_valid),
    .in_ready  (conv_ready),
    .in_sum    (group_sum),
    .offset_mv (sensor_offset_mv),
    .out_valid (conv_valid),
    .out_ready (result_ready),
    .out_avg   (conv_avg),
    .out_temp  (conv_temp)
  );

  // output register loads when empty or being taken
  assign result_ready = !result.valid || result.ready;
  assign reading_take = conv_valid && result_ready;

  // running extremes
  assign lowest_next  = (conv_temp < lowest_temp)  ? conv_temp : lowest_temp;
  assign highest_next = (conv_temp > highest_temp) ? conv_temp : highest_temp;

  // event versus the previous reading
  assign delta   = DeltaW'(conv_temp) - DeltaW'(previous_temp);
  assign thr_pos = $signed({2'b00, event_threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    kind_next = KindNone;
    if (previous_valid) begin
      if (delta >= thr_pos) begin
        kind_next = KindWarming;
      end else if (delta <= thr_neg) begin
        kind_next = KindCooling;
      end
    end
  end

  // summary counter; a zero interval acts as one
  assign interval_eff = (summary_period == '0) ? IntW'(1) : summary_period;
  assign count_inc    = {1'b0, readings_mod_interval} + (IntW + 1)'(1);
  assign due_next     = (count_inc >= {1'b0, interval_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_temp           <= TempMaxValue;
      highest_temp          <= TempMinValue;
      previous_temp         <= '0;
      previous_valid        <= 1'b0;
      readings_mod_interval <= '0;
      result.valid          <= 1'b0;
    end else begin
      if (result_ready) begin
        result.valid <= conv_valid;
      end
      if (reading_take) begin
        lowest_temp           <= lowest_next;
        highest_temp          <= highest_next;
        previous_temp         <= conv_temp;
        previous_valid        <= 1'b1;
        readings_mod_interval <= due_next ? '0 : count_inc[IntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reading_take) begin
      result.average_raw  <= conv_avg;
      result.temperature  <= conv_temp;
      result.minimum_seen <= lowest_next;
      result.maximum_seen <= highest_next;
      result.event_kind   <= kind_next;
      result.summary_due  <= due_next;
    end
  end

  // checks
  `DTM_ASSERT_IMPLIES(a_min_le_max, result.valid, result.minimum_seen <= result.maximum_seen, "running minimum above running maximum")
  `DTM_ASSERT_IMPLIES(a_temp_in_range, result.valid, (result.temperature >= result.minimum_seen) && (result.temperature <= result.maximum_seen), "temperature outside running extremes")
  `DTM_ASSERT_IMPLIES(a_count_bound, 1'b1, samples_taken <= CountW'(AVG_SAMPLES - 1), "sample counter passed group size")
  `DTM_ASSERT_NEXT(a_conv_held, conv_valid && !result_ready, conv_valid, "converted reading dropped while output stalled")

endmodule

[tb/sv/tb_die_temperature_monitor.sv]
`timescale 1ns / 1ps
// self-checking testbench for die_temperature_monitor: a directed table, then randomized
// phases with register changes; readings checked vs table rows or an in-line predictor
// depends on dtm_pkg, the dtm channel interfaces and die_temperature_monitor
module tb_die_temperature_monitor;
  import dtm_pkg::*;

  localparam int GroupSize = 3;
  localparam int SettleCycles = 8;
  localparam int EndCycles = 20;
  localparam int unsigned CycleLimit = 200000;
  localparam int ReportLimit = 10;
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 125;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // one temperature reading as it leaves the block
  typedef struct packed {
    logic [RawW-1:0]         avg;
    logic signed [TempW-1:0] temp;
    logic signed [TempW-1:0] lo;
    logic signed [TempW-1:0] hi;
    logic [KindW-1:0]        kind;
    logic                    due;
  } reading_t;

  // one row of the directed table: a sample or a register write
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [RawW-1:0]    value;
    logic               known;
    reading_t           want;
  } row_t;

  logic clk;
  logic rst;

  dtm_sample_if sample_ch();
  dtm_cfg_if    cfg_ch();
  dtm_result_if result_ch();

  die_temperature_monitor #(.AVG_SAMPLES(GroupSize)) DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  // predictor state and register copies
  logic [15:0]     group_sum;
  logic [3:0]      group_count;
  int              low_mark;
  int              high_mark;
  int              last_temp;
  bit              last_valid;
  logic [IntW-1:0] reading_count;
  logic [ThrW-1:0] thr_reg;
  logic [OffW-1:0] offset_reg;
  logic [IntW-1:0] interval_reg;

  reading_t    readings_in_flight[$];
  row_t        stimulus_table[$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // fold one sample into the group; returns 1 with the reading when a group closes
  function automatic bit fold_sample(input logic [RawW-1:0] raw, output reading_t r);
    int unsigned avg;
    int unsigned mv;
    int unsigned interval;
    int unsigned count;
    int          diff;
    int          temp;
    int          delta;
    r = '0;
    group_sum = group_sum + 16'(raw);
    group_count = group_count + 4'd1;
    if (group_count < GroupSize) return 1'b0;

    avg = (32'(group_sum) / GroupSize) & 32'hFFF;
    group_sum = '0;
    group_count = '0;

    // millivolts, then tenths of a degree with truncation toward zero
    mv = (avg * VrefMv) >> AdcBits;
    diff = int'(mv) - int'(offset_reg);
    temp = diff * 10 / MvPerDegX10 + RefTenths;
    if (temp < low_mark) low_mark = temp;
    if (temp > high_mark) high_mark = temp;

    // event versus the previous reading, none on the first one
    r.kind = KindNone;
    if (last_valid) begin
      delta = temp - last_temp;
      if (delta >= int'(thr_reg)) r.kind = KindWarming;
      else if (delta <= -int'(thr_reg)) r.kind = KindCooling;
    end
    last_temp = temp;
    last_valid = 1'b1;

    // summary flag; an interval of zero acts as one
    interval = (interval_reg == '0) ? 1 : 32'(interval_reg);
    count = 32'(reading_count) + 1;
    if (count >= interval) begin
      r.due = 1'b1;
      count = 0;
    end
    reading_count = IntW'(count);

    r.avg = RawW'(avg);
    r.temp = TempW'(temp);
    r.lo = TempW'(low_mark);
    r.hi = TempW'(high_mark);
    return 1'b1;
  endfunction

  // chance of an idle burst, per phase
  function automatic int burst_odds();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic row_sample(input logic [RawW-1:0] raw);
    row_t r;
    r = '0;
    r.value = raw;
    stimulus_table.push_back(r);
  endtask

  task automatic row_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = RawW'(value);
    stimulus_table.push_back(r);
  endtask

  task automatic row_known(input logic [RawW-1:0] raw, input int avg, input int temp,
                           input int lo, input int hi, input logic [KindW-1:0] kind,
                           input logic due);
    row_t r;
    r = '0;
    r.value = raw;
    r.known = 1'b1;
    r.want.avg = RawW'(avg);
    r.want.temp = TempW'(temp);
    r.want.lo = TempW'(lo);
    r.want.hi = TempW'(hi);
    r.want.kind = kind;
    r.want.due = due;
    stimulus_table.push_back(r);
  endtask

  // wait until every reading is back and the group stage has drained
  task automatic settle();
    while (readings_in_flight.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one register transfer; cfg valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CfgEventThreshold:  thr_reg = data[ThrW-1:0];
      CfgSensorOffset:    offset_reg = data[OffW-1:0];
      CfgSummaryInterval: interval_reg = data[IntW-1:0];
      default: ;
    endcase
  endtask

  // one sample transfer, with an optional idle burst ahead of it
  task automatic push_sample(input logic [RawW-1:0] raw, input logic known,
                             input reading_t want);
    reading_t got;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.raw_sample <= raw;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (fold_sample(raw, got)) readings_in_flight.push_back(known ? want : got);
  endtask

  // result ready with random stall bursts
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest pending reading
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.avg = result_ch.average_raw;
      got.temp = result_ch.temperature;
      got.lo = result_ch.minimum_seen;
      got.hi = result_ch.maximum_seen;
      got.kind = result_ch.event_kind;
      got.due = result_ch.summary_due;
      if (readings_in_flight.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t unexpected reading: avg %0d temp %0d", $time, got.avg,
                   $signed(got.temp));
      end else begin
        want = readings_in_flight.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t reading (expected/actual): avg %0d/%0d temp %0d/%0d", $time,
                     want.avg, got.avg, $signed(want.temp), $signed(got.temp));
            $display("  min %0d/%0d max %0d/%0d kind %0d/%0d summary %0d/%0d",
                     $signed(want.lo), $signed(got.lo), $signed(want.hi), $signed(got.hi),
                     want.kind, got.kind, want.due, got.due);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    bit              in_cfg;
    int              base;
    int              pick;
    logic [RawW-1:0] raw;
    logic [CfgDataW-1:0] thr_val;
    logic [CfgDataW-1:0] off_val;
    logic [CfgDataW-1:0] int_val;
    reading_t        none;

    in_cfg = 1'b0;
    none = '0;
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.raw_sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;

    // predictor state after reset
    group_sum = '0;
    group_count = '0;
    low_mark = int'(TempMaxValue);
    high_mark = int'(TempMinValue);
    last_temp = 0;
    last_valid = 1'b0;
    reading_count = '0;
    thr_reg = ThrReset;
    offset_reg = OffsetReset;
    interval_reg = IntervalReset;

    // directed: rail samples at the default registers, first reading has no event
    row_sample(12'h000);
    row_sample(12'h000);
    row_known(12'h000, 0, -27, -27, -27, KindNone, 1'b0);
    row_sample(12'hFFF);
    row_sample(12'hFFF);
    row_known(12'hFFF, 4095, 490, -27, 490, KindWarming, 1'b0);
    row_sample(12'hFFF);
    row_sample(12'hFFF);
    row_sample(12'h000);
    // zero threshold, zero interval below the running count, offset past the sensor range
    row_cfg(CfgEventThreshold, 11'd0);
    row_cfg(CfgSummaryInterval, 11'd0);
    row_cfg(CfgSensorOffset, 11'd2047);
    row_sample(12'h000);
    row_sample(12'h000);
    row_known(12'h000, 0, -508, -508, 490, KindCooling, 1'b1);
    row_sample(12'h000);
    row_sample(12'h000);
    row_known(12'h000, 0, -508, -508, 490, KindWarming, 1'b1);
    // widest threshold and interval, zero offset, write to the unused index
    row_cfg(CfgEventThreshold, 11'd1023);
    row_cfg(CfgSensorOffset, 11'd0);
    row_cfg(CfgSummaryInterval, 11'd255);
    row_cfg(CfgUnused, 11'h7FF);
    row_sample(12'hFFF);
    row_sample(12'hFFF);
    row_known(12'hFFF, 4095, 768, -508, 768, KindWarming, 1'b0);
    row_sample(12'h800);
    row_sample(12'h7FF);
    row_sample(12'h001);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (stimulus_table[i]) begin
      if (stimulus_table[i].is_cfg) begin
        if (!in_cfg) begin
          sample_ch.valid <= 1'b0;
          settle();
        end
        write_reg(stimulus_table[i].idx, CfgDataW'(stimulus_table[i].value));
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_ch.valid <= 1'b0;
        in_cfg = 1'b0;
        push_sample(stimulus_table[i].value, stimulus_table[i].known,
                    stimulus_table[i].want);
      end
    end

    // random phases, registers changed while idle
    for (int p = 0; p < PhaseCount; p++) begin
      sample_ch.valid <= 1'b0;
      settle();
      if (p == 0) begin
        thr_val = 11'd1000;
        off_val = 11'd1400;
        int_val = 11'd255;
      end else if (p == 1) begin
        thr_val = 11'd0;
        off_val = 11'd0;
        int_val = 11'd1;
      end else begin
        case ($urandom_range(3))
          0: thr_val = 11'd0;
          1: thr_val = CfgDataW'($urandom_range(1000));
          2: thr_val = CfgDataW'($urandom_range(60));
          default: thr_val = CfgDataW'($urandom_range(2047));
        endcase
        case ($urandom_range(3))
          0: off_val = CfgDataW'(OffsetReset);
          1: off_val = CfgDataW'($urandom_range(1400));
          2: off_val = CfgDataW'($urandom_range(2047));
          default: off_val = CfgDataW'($urandom_range(600, 900));
        endcase
        case ($urandom_range(3))
          0: int_val = CfgDataW'($urandom_range(1, 255));
          1: int_val = CfgDataW'($urandom_range(3));
          2: int_val = CfgDataW'($urandom_range(2047));
          default: int_val = CfgDataW'($urandom_range(1, 12));
        endcase
      end
      write_reg(CfgEventThreshold, thr_val);
      write_reg(CfgSensorOffset, off_val);
      write_reg(CfgSummaryInterval, int_val);
      cfg_ch.valid <= 1'b0;

      // the last phase runs with no idling on either side
      gap_pct = (p == PhaseCount - 1) ? 0 : burst_odds();
      stall_pct = (p == PhaseCount - 1) ? 0 : burst_odds();

      // mostly a slowly drifting sensor, some noise and rail values
      base = $urandom_range(4095);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          base = base + int'($urandom_range(40)) - 20;
          if (base < 0) base = 0;
          if (base > 4095) base = 4095;
          raw = RawW'(base);
        end else if (pick < 90) begin
          raw = RawW'($urandom_range(4095));
        end else begin
          raw = $urandom_range(1) ? 12'hFFF : 12'h000;
        end
        push_sample(raw, 1'b0, none);
      end
    end

    // drain and report
    sample_ch.valid <= 1'b0;
    while (readings_in_flight.size() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (mismatches == 0 && readings_in_flight.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
